/* rtl/gesf_pkg.sv */
// shared constants and register codes for the glyph edge soften filter
`default_nettype none
package gesf_pkg;

   localparam int PIXEL_W        = 8;
   localparam int ROW_W          = 12;
   localparam int OUT_COL_W      = 10;
   localparam int RSP_DATA_W     = 32;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int FONT_HEIGHT_W  = 12;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;

   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_HEIGHT       = 4096;
   localparam int FRAME_WIDTH_RST  = 1024;
   localparam int FRAME_HEIGHT_RST = 16;
   localparam int MIN_SIZE         = 3;

   localparam logic [FONT_HEIGHT_W-1:0] BYPASS_LIMIT = 12'd14;
   localparam logic [FONT_HEIGHT_W-1:0] EIGHT_LIMIT  = 12'd18;

   // x / 10 == (x * 3277) >> 15 for every x below 2048
   localparam int SUM_W       = 11;
   localparam int RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP_10 = 12'd3277;
   localparam int RECIP_SHIFT = 15;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FONT_HEIGHT  = 2'd2;

endpackage
`default_nettype wire

/* rtl/gesf_ram.sv */
// simple dual port ram with registered read
`default_nettype none
module gesf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/glyph_edge_soften_filter_core.sv */
// top level: 3x3 edge soften filter over a raster stream of coverage bytes
// each word is registered in the compute stage, its result in the result register
// throughput: one word per cycle unless results stall; the line store read is
//   issued on accept and its registered data meets the word in the compute stage
// reset clears the position counters, the window registers, the pipeline valid
//   flags and the size/font registers to their defaults; line stores are not cleared
`default_nettype none
module glyph_edge_soften_filter_core #(
   parameter int MAX_WIDTH = gesf_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [gesf_pkg::PIXEL_W-1:0]      req_tdata,  // [7:0] pixel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] value, [19:8] out_row, [29:20] out_col, [31:30] zero
   output logic      [gesf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tlast,  // frame_end
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gesf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gesf_pkg::CSR_DATA_W-1:0]   csr_data
);

   import gesf_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WIDTH_RST_EFF =
      (FRAME_WIDTH_RST < MAX_WIDTH) ? FRAME_WIDTH_RST : MAX_WIDTH;
   localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(WIDTH_RST_EFF - 1);
   localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(FRAME_HEIGHT_RST - 1);

   // configuration
   logic [COL_W-1:0]         col_last_ff, col_last_in;
   logic [ROW_W-1:0]         row_last_ff, row_last_in;
   logic [FONT_HEIGHT_W-1:0] font_ff, font_in;
   logic                     csr_write;
   logic [31:0]              cfg_w32, cfg_h32;

   // position of the next input word
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // compute stage
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_interior_ff;
   logic               s1_last_ff;
   logic               s1_adv;
   logic               s1_emit;
   logic               req_accept;

   logic [PIXEL_W-1:0] window_ff [6];
   logic [PIXEL_W-1:0] top_rd, mid_rd;

   logic                        bypass, eight;
   logic [SUM_W-2:0]            edge_sum;
   logic [SUM_W-1:0]            full_sum, dividend;
   logic [SUM_W+RECIP_W-1:0]    product;
   logic [PIXEL_W-1:0]          soft_value, value_in;
   logic [ROW_W-1:0]            out_row_in;
   logic [OUT_COL_W-1:0]        out_col_in;

   // result register
   logic                 rsp_valid_ff;
   logic [PIXEL_W-1:0]   rsp_value_ff;
   logic [ROW_W-1:0]     rsp_row_ff;
   logic [OUT_COL_W-1:0] rsp_col_ff;
   logic                 rsp_last_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   assign cfg_w32 = 32'(csr_data[FRAME_WIDTH_W-1:0]);
   assign cfg_h32 = 32'(csr_data[FRAME_HEIGHT_W-1:0]);

   // sizes are saturated once at write time and kept as last index
   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      font_in     = font_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               if (cfg_w32 < 32'(MIN_SIZE)) begin
                  col_last_in = COL_W'(MIN_SIZE - 1);
               end else if (cfg_w32 > 32'(MAX_WIDTH)) begin
                  col_last_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  col_last_in = COL_W'(cfg_w32 - 32'd1);
               end
            end
            REG_FRAME_HEIGHT: begin
               if (cfg_h32 < 32'(MIN_SIZE)) begin
                  row_last_in = ROW_W'(MIN_SIZE - 1);
               end else if (cfg_h32 > 32'(MAX_HEIGHT)) begin
                  row_last_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  row_last_in = ROW_W'(cfg_h32 - 32'd1);
               end
            end
            REG_FONT_HEIGHT: begin
               font_in = csr_data[FONT_HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign s1_emit    = bypass | s1_interior_ff;
   assign s1_adv     = s1_valid_ff & (~s1_emit | ~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign req_accept = req_tvalid & req_tready;

   // position counters, restarted by a size write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write && (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT)) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_ff == col_last_ff) begin
            col_in = '0;
            row_in = (row_ff == row_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   gesf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (top_rd)
   );

   gesf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (mid_rd)
   );

   // window: regs 0..2 are column c-2, regs 3..5 column c-1 (top, mid, bottom)
   assign bypass   = (font_ff <= BYPASS_LIMIT);
   assign eight    = (font_ff > EIGHT_LIMIT);
   assign edge_sum = (SUM_W-1)'(window_ff[3]) + (SUM_W-1)'(window_ff[1])
                   + (SUM_W-1)'(window_ff[5]) + (SUM_W-1)'(mid_rd);
   assign full_sum = SUM_W'(edge_sum) + SUM_W'(window_ff[0]) + SUM_W'(window_ff[2])
                   + SUM_W'(top_rd) + SUM_W'(s1_pixel_ff);
   // edge / 5 is the same as (2 * edge) / 10, so one reciprocal serves both
   assign dividend   = eight ? full_sum : {edge_sum, 1'b0};
   assign product    = (SUM_W+RECIP_W)'(dividend) * (SUM_W+RECIP_W)'(RECIP_10);
   assign soft_value = PIXEL_W'(product >> RECIP_SHIFT);

   always_comb begin
      if (bypass) begin
         value_in   = s1_pixel_ff;
         out_row_in = s1_row_ff;
         out_col_in = OUT_COL_W'(s1_col_ff);
      end else begin
         value_in   = (window_ff[4] != '0) ? window_ff[4] : soft_value;
         out_row_in = s1_row_ff - 1'b1;
         out_col_in = OUT_COL_W'(s1_col_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff  <= COL_LAST_RST;
         row_last_ff  <= ROW_LAST_RST;
         font_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         font_ff     <= font_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            window_ff[0] <= window_ff[3];
            window_ff[1] <= window_ff[4];
            window_ff[2] <= window_ff[5];
            window_ff[3] <= top_rd;
            window_ff[4] <= mid_rd;
            window_ff[5] <= s1_pixel_ff;
         end
         if (s1_adv && s1_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_tdata;
         s1_col_ff      <= col_ff;
         s1_row_ff      <= row_ff;
         s1_interior_ff <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff     <= (row_ff == row_last_ff) && (col_ff == col_last_ff);
      end
      if (s1_adv && s1_emit) begin
         rsp_value_ff <= value_in;
         rsp_row_ff   <= out_row_in;
         rsp_col_ff   <= out_col_in;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_row_ff, rsp_value_ff};

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= col_last_ff)
      else $error("column counter past last column");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= row_last_ff)
      else $error("row counter past last row");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_adv && s1_emit))
      else $error("pending result word overwritten");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stalled compute stage lost its word");

endmodule
`default_nettype wire

/* tb/sv/soften_filter_monitor.sv */
// stream monitor for the edge soften filter: predicts each result word and checks it
`timescale 1ns / 1ps
module soften_filter_monitor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [gesf_pkg::PIXEL_W-1:0]      req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [gesf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              rsp_tlast,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [gesf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gesf_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                fail_count,
   output int                                pending
);

   import gesf_pkg::*;

   localparam int EIGHT_DIVISOR = 10;
   localparam int FOUR_DIVISOR  = 5;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [PIXEL_W-1:0]   value;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 frame_end;
   } soft_pixel_type;

   soft_pixel_type expected_pixels[$];
   soft_pixel_type want;

   logic [FRAME_WIDTH_W-1:0]  width_reg;
   logic [FRAME_HEIGHT_W-1:0] height_reg;
   logic [FONT_HEIGHT_W-1:0]  font_reg;

   logic [PIXEL_W-1:0] upper_line [MAX_WIDTH_DEF];
   logic [PIXEL_W-1:0] middle_line [MAX_WIDTH_DEF];
   logic [PIXEL_W-1:0] win [6];
   int unsigned row_cnt;
   int unsigned col_cnt;
   int mismatches = 0;

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_fault(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, what);
   endtask

   // one pixel through the window; queues the word it emits, if any
   task automatic soften_predict(input logic [PIXEL_W-1:0] px);
      int unsigned w, h, r, c, center, edge_sum, v;
      logic [PIXEL_W-1:0] top_px, mid_px;
      soft_pixel_type res;
      w = width_reg;
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
      h = height_reg;
      if (h < MIN_SIZE) h = MIN_SIZE;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      r = row_cnt;
      c = col_cnt;
      if (r >= h) r = h - 1;
      if (c >= w) c = w - 1;
      top_px = upper_line[c];
      mid_px = middle_line[c];

      if (font_reg <= BYPASS_LIMIT) begin
         res.value = px;
         res.row = r[ROW_W-1:0];
         res.col = c[OUT_COL_W-1:0];
         res.frame_end = (r == h - 1) && (c == w - 1);
         expected_pixels.push_back(res);
      end else if (r >= 2 && c >= 2) begin
         // win[0..2] is column c-2, win[3..5] column c-1, top/mid/px column c
         center = win[4];
         v = center;
         if (center == 0) begin
            edge_sum = win[3] + win[1] + win[5] + mid_px;
            if (font_reg > EIGHT_LIMIT)
               v = (edge_sum + win[0] + win[2] + top_px + px) / EIGHT_DIVISOR;
            else
               v = edge_sum / FOUR_DIVISOR;
         end
         res.value = v[PIXEL_W-1:0];
         res.row = ROW_W'(r - 1);
         res.col = OUT_COL_W'(c - 1);
         res.frame_end = (r == h - 1) && (c == w - 1);
         expected_pixels.push_back(res);
      end

      upper_line[c] = mid_px;
      middle_line[c] = px;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top_px;
      win[4] = mid_px;
      win[5] = px;

      if (c + 1 >= w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
         row_cnt = r;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
         height_reg = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
         font_reg = '0;
         for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
         end
         for (int i = 0; i < 6; i++) win[i] = '0;
         row_cnt = 0;
         col_cnt = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  width_reg = csr_data[FRAME_WIDTH_W-1:0];
                  row_cnt = 0;
                  col_cnt = 0;
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_data[FRAME_HEIGHT_W-1:0];
                  row_cnt = 0;
                  col_cnt = 0;
               end
               REG_FONT_HEIGHT: font_reg = csr_data[FONT_HEIGHT_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_fault($sformatf("result word with nothing expected: tdata %h tlast %b",
                                      rsp_tdata, rsp_tlast));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== {2'b00, want.col, want.row, want.value} ||
                   rsp_tlast !== want.frame_end)
                  report_fault($sformatf(
                     {"exp value %0d row %0d col %0d end %b, ",
                      "got value %0d row %0d col %0d end %b pad %b"},
                     want.value, want.row, want.col, want.frame_end,
                     rsp_tdata[7:0], rsp_tdata[19:8], rsp_tdata[29:20], rsp_tlast,
                     rsp_tdata[31:30]));
            end
         end

         if (req_tvalid && req_tready) soften_predict(req_tdata);
      end
      pending <= expected_pixels.size();
      fail_count <= mismatches;
   end

endmodule

/* tb/sv/tb_glyph_edge_soften_filter_core.sv */
// top of the edge soften filter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_glyph_edge_soften_filter_core;
   import gesf_pkg::*;

   localparam int RANDOM_PIXELS = 500;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;
   int          sink_hold = 0;
   logic        sink_steady = 1'b0;
   bit          source_steady = 1'b0;

   glyph_edge_soften_filter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   soften_filter_monitor monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold <= 0;
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
      end else begin
         rsp_tready <= sink_steady || ($urandom_range(0, 2) != 0);
         sink_hold <= idle_len();
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      // mono coverage is mostly 0 or 255
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_width();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return CSR_DATA_W'($urandom_range(0, 2));
      // bits above the register width must be dropped
      if (pick == 1)
         return CSR_DATA_W'($urandom_range(13, 48) | ($urandom_range(0, 3) << FRAME_WIDTH_W));
      return CSR_DATA_W'($urandom_range(3, 12));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      int pick;
      pick = $urandom_range(0, 11);
      if (pick == 0) return CSR_DATA_W'($urandom_range(0, 2));
      if (pick == 1) return CSR_DATA_W'(MAX_HEIGHT);
      if (pick == 2) return CSR_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
      return CSR_DATA_W'($urandom_range(3, 10));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_font();
      case ($urandom_range(0, 7))
         0: return CSR_DATA_W'($urandom_range(0, 14));
         1: return CSR_DATA_W'(BYPASS_LIMIT);
         2: return CSR_DATA_W'(BYPASS_LIMIT) + 1'b1;
         3: return CSR_DATA_W'(EIGHT_LIMIT);
         4: return CSR_DATA_W'(EIGHT_LIMIT) + 1'b1;
         5: return 13'hFFF;
         6: return CSR_DATA_W'($urandom_range(15, 18));
         default: return CSR_DATA_W'($urandom_range(19, 4095));
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      int gap;
      gap = source_steady ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
   endtask

   // block idle: every result word back, border words flushed
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent;
      int n;
      int ew;
      int eh;
      bit paused;
      logic [CSR_DATA_W-1:0] w_val;
      logic [CSR_DATA_W-1:0] h_val;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default setup passes pixels straight through
      send_pixel(8'h00);
      send_pixel(8'hFF);
      settle();

      // sizes below the minimum saturate to a 3x3 frame, eight neighbours
      write_reg(REG_FRAME_WIDTH, 13'd0);
      write_reg(REG_FRAME_HEIGHT, 13'd2);
      write_reg(REG_FONT_HEIGHT, CSR_DATA_W'(EIGHT_LIMIT) + 1'b1);
      write_reg(REG_SPARE, 13'h1FFF);
      csr_valid <= 1'b0;
      for (int i = 0; i < 9; i++)
         send_pixel((i == 0 || i == 2 || i == 6 || i == 8) ? 8'hFF : 8'h00);
      settle();

      // edge neighbours only, frame carries on from the top row
      write_reg(REG_FONT_HEIGHT, CSR_DATA_W'(BYPASS_LIMIT) + 1'b1);
      csr_valid <= 1'b0;
      for (int i = 0; i < 9; i++)
         send_pixel((i == 1 || i == 3 || i == 5 || i == 7) ? 8'hFF : 8'h00);
      settle();

      // widest frame in bypass at the limit: width and height above the maximum saturate
      w_val = 13'd2047;
      h_val = 13'h1FFF;
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
      write_reg(REG_FONT_HEIGHT, CSR_DATA_W'(BYPASS_LIMIT));
      csr_valid <= 1'b0;
      for (int i = 0; i < MAX_WIDTH_DEF + 8; i++) send_pixel(pick_pixel());
      settle();

      sent = 0;
      paused = 0;
      while (sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 3) == 0) begin
            // mode change in the middle of a frame
            write_reg(REG_FONT_HEIGHT, pick_font());
         end else begin
            w_val = pick_width();
            h_val = pick_height();
            write_reg(REG_FRAME_WIDTH, w_val);
            write_reg(REG_FRAME_HEIGHT, h_val);
            write_reg(REG_FONT_HEIGHT, pick_font());
            if ($urandom_range(0, 7) == 0)
               write_reg(REG_SPARE, CSR_DATA_W'($urandom_range(0, 8191)));
         end
         csr_valid <= 1'b0;

         ew = w_val[FRAME_WIDTH_W-1:0];
         ew = (ew < MIN_SIZE) ? MIN_SIZE : (ew > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : ew;
         eh = h_val;
         eh = (eh < MIN_SIZE) ? MIN_SIZE : (eh > MAX_HEIGHT) ? MAX_HEIGHT : eh;
         if (ew * eh > 300) n = $urandom_range(20, 200);
         else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, ew * eh);
         else n = ew * eh * $urandom_range(1, 2);

         source_steady = ($urandom_range(0, 3) == 0);
         sink_steady <= ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) begin
            send_pixel(pick_pixel());
            sent++;
            if (!paused && sent > RANDOM_PIXELS / 2) begin
               paused = 1;
               req_tvalid <= 1'b0;
               do @(posedge clock); while (pending != 0);
            end
         end
         settle();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
